// ----- hw/rtl/rpm_pkg.sv -----
// Shared types, constants and microcode for the point motion step unit.
package rpm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int ELAST_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELAST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TH   = 3'd4;

    localparam logic [2:0] FN_PLACE  = 3'd0;
    localparam logic [2:0] FN_PUSH   = 3'd1;
    localparam logic [2:0] FN_COAST  = 3'd2;
    localparam logic [2:0] FN_BNC_H  = 3'd3;
    localparam logic [2:0] FN_BNC_V  = 3'd4;
    localparam logic [2:0] FN_STOP   = 3'd5;

    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic signed [33:0] HALF_Q      = 34'sd2147483648;
    localparam logic signed [33:0] QUARTER_Q   = 34'sd1073741824;
    localparam logic signed [63:0] NORM_LIMIT  = 64'sd70368744177664; // 2^46

    localparam int PC_W = 7;

    typedef struct packed {
        logic [2:0]         func;
        logic [15:0]        angle_in;
        logic signed [31:0] magnitude;
        logic [19:0]        delta_time;
        logic signed [31:0] offset;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [15:0]        heading;
    } t_out_word;

    typedef enum logic [5:0] {
        U_NOP, U_PLACE, U_LOAD_PUSH, U_STOP, U_SINCOS, U_ATAN, U_SQRT, U_DIV_X, U_DIV_Y,
        U_M_C_IMP, U_M_S_IMP, U_M_T0_INVM, U_M_T1_INVM, U_M_T0_DT, U_M_T1_DT,
        U_M_VX_DT, U_M_VY_DT, U_M_VX_VX, U_M_VY_VY, U_M_VX_LIM, U_M_VY_LIM,
        U_M_FRIC_DT, U_M_VX_FAC, U_M_VY_FAC, U_M_VX_NEL, U_M_VY_NEL, U_M_C_OFF, U_M_S_OFF,
        U_W_T0_30, U_W_T1_30, U_W_T0_F, U_W_T1_F, U_W_VX_ADD, U_W_VY_ADD,
        U_W_PX_ADD, U_W_PY_ADD, U_W_SQ0, U_W_SQ1, U_W_FACT, U_W_VX_F, U_W_VY_F,
        U_W_VX_E, U_W_VY_E, U_W_PX_30, U_W_PY_30, U_LIMCHK, U_HNEG, U_HREFL, U_SNAP
    } t_uop;

    typedef struct packed {
        t_uop op;
        logic last;
    } t_uinst;

    typedef struct packed {
        t_uop op;
        logic go;
        logic load_in;
        logic load_out;
    } t_cmd;

    function automatic logic [29:0] atan_q32(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // semi-implicit Euler: velocity first, then position from the new velocity
    function automatic t_uop euler_op(input logic [4:0] k);
        t_uop op;
        case (k)
            5'd0:  op = U_SINCOS;
            5'd1:  op = U_M_C_IMP;
            5'd2:  op = U_W_T0_30;
            5'd3:  op = U_M_S_IMP;
            5'd4:  op = U_W_T1_30;
            5'd5:  op = U_M_T0_INVM;
            5'd6:  op = U_W_T0_F;
            5'd7:  op = U_M_T1_INVM;
            5'd8:  op = U_W_T1_F;
            5'd9:  op = U_M_T0_DT;
            5'd10: op = U_W_VX_ADD;
            5'd11: op = U_M_T1_DT;
            5'd12: op = U_W_VY_ADD;
            5'd13: op = U_M_VX_DT;
            5'd14: op = U_W_PX_ADD;
            5'd15: op = U_M_VY_DT;
            5'd16: op = U_W_PY_ADD;
            default: op = U_NOP;
        endcase
        return op;
    endfunction

    function automatic t_uinst uc_rom(input logic [PC_W-1:0] pc);
        t_uinst u;
        u.op   = U_NOP;
        u.last = 1'b0;
        if (pc >= 7'd4 && pc <= 7'd20) begin
            u.op = euler_op(5'(pc - 7'd4));
        end else if (pc >= 7'd22 && pc <= 7'd38) begin
            u.op = euler_op(5'(pc - 7'd22));
        end else begin
            case (pc)
                7'd0:  begin u.op = U_PLACE;     u.last = 1'b1; end
                7'd1:  begin u.op = U_STOP;      u.last = 1'b1; end
                7'd2:  begin u.op = U_NOP;       u.last = 1'b1; end
                7'd3:  u.op = U_LOAD_PUSH;
                7'd21: begin u.op = U_SNAP;      u.last = 1'b1; end
                7'd39: u.op = U_M_VX_VX;
                7'd40: u.op = U_W_SQ0;
                7'd41: u.op = U_M_VY_VY;
                7'd42: u.op = U_W_SQ1;
                7'd43: u.op = U_SQRT;
                7'd44: u.op = U_LIMCHK;
                7'd45: u.op = U_M_VX_LIM;
                7'd46: u.op = U_DIV_X;
                7'd47: u.op = U_M_VY_LIM;
                7'd48: u.op = U_DIV_Y;
                7'd49: u.op = U_ATAN;
                7'd50: u.op = U_M_FRIC_DT;
                7'd51: u.op = U_W_FACT;
                7'd52: u.op = U_M_VX_FAC;
                7'd53: u.op = U_W_VX_F;
                7'd54: u.op = U_M_VY_FAC;
                7'd55: u.op = U_W_VY_F;
                7'd56: begin u.op = U_SNAP;      u.last = 1'b1; end
                7'd57: u.op = U_M_VY_NEL;
                7'd58: u.op = U_W_VY_E;
                7'd59: u.op = U_HNEG;
                7'd60: u.op = U_SINCOS;
                7'd61: u.op = U_M_S_OFF;
                7'd62: begin u.op = U_W_PY_30;   u.last = 1'b1; end
                7'd63: u.op = U_M_VX_NEL;
                7'd64: u.op = U_W_VX_E;
                7'd65: u.op = U_HREFL;
                7'd66: u.op = U_SINCOS;
                7'd67: u.op = U_M_C_OFF;
                7'd68: begin u.op = U_W_PX_30;   u.last = 1'b1; end
                default: begin u.op = U_NOP;     u.last = 1'b1; end
            endcase
        end
        return u;
    endfunction

    function automatic logic [PC_W-1:0] uc_start(input logic [2:0] func);
        logic [PC_W-1:0] pc;
        case (func)
            FN_PLACE: pc = 7'd0;
            FN_STOP:  pc = 7'd1;
            FN_PUSH:  pc = 7'd3;
            FN_COAST: pc = 7'd22;
            FN_BNC_H: pc = 7'd57;
            FN_BNC_V: pc = 7'd63;
            default:  pc = 7'd2;
        endcase
        return pc;
    endfunction

    function automatic logic is_long(input t_uop op);
        logic l;
        case (op)
            U_SINCOS, U_ATAN, U_SQRT, U_DIV_X, U_DIV_Y: l = 1'b1;
            default: l = 1'b0;
        endcase
        return l;
    endfunction

endpackage

// ----- hw/rtl/rigid_point_motion_step_unit.sv -----
// Top level of the 2D point object motion step unit.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-------------------------------
//  in      | in        | i_in_valid / o_in_stall    | t_in_word: func and operands
//  out     | out       | o_out_valid / i_out_stall  | t_out_word: state after step
//  cfg     | in        | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// One word at a time. Place, stop and unused codes use no serial unit; push and the
// bounces run one CORDIC rotation, and coast runs a rotation, a square root, two
// divides and a CORDIC vectoring that first normalises its vector. The next input
// word can be taken once the result has been loaded into the output register.
// Synchronous active-low reset; a finished word waits in the output register while the
// next input word is taken, and a stalled output holds the next result back.
module rigid_point_motion_step_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rpm_pkg::t_in_word              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rpm_pkg::t_out_word             o_out,
    input  logic                           i_cfg_wr_en,
    input  logic [rpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpm_pkg::*;

    t_cmd cmd;
    logic unit_done;

    rpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in.func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_unit_done (unit_done)
    );

    rpm_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_unit_done (unit_done),
        .i_in        (i_in),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );

endmodule

// ----- hw/rtl/rpm_cordic.sv -----
// Iterative CORDIC: sine/cosine by rotation, atan2 by vectoring.
module rpm_cordic #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start_rot,
    input  logic                  i_start_vec,
    input  logic [ANGLE_BITS-1:0] i_angle,
    input  logic signed [31:0]    i_x,
    input  logic signed [31:0]    i_y,
    output logic                  o_done,
    output logic signed [31:0]    o_cos,
    output logic signed [31:0]    o_sin,
    output logic [ANGLE_BITS-1:0] o_angle
);
    import rpm_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_NORM = 3'b010,
        CS_ITER = 3'b100
    } t_cs;

    t_cs                r_st;
    logic signed [63:0] r_x, r_y;
    logic signed [33:0] r_z;
    logic               r_rot, r_neg, r_done;
    logic [CW-1:0]      r_cnt;

    logic [31:0]        a32;
    logic signed [33:0] z0;
    logic signed [63:0] x64, y64, ysh, xsh, ay;
    logic signed [33:0] atn;
    logic               ccw;
    logic [32:0]        zsum;

    always_comb begin
        a32  = 32'(i_angle) << (32 - ANGLE_BITS);
        z0   = {{2{a32[31]}}, a32};
        x64  = 64'(i_x);
        y64  = 64'(i_y);
        ysh  = r_y >>> r_cnt;
        xsh  = r_x >>> r_cnt;
        ay   = r_y[63] ? -r_y : r_y;
        atn  = $signed({4'b0, atan_q32(5'(r_cnt))});
        ccw  = r_rot ? !r_z[33] : r_y[63];
        zsum = {1'b0, r_z[31:0]} + (33'd1 << (31 - ANGLE_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= CS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                CS_IDLE: begin
                    if (i_start_rot) begin
                        r_rot <= 1'b1;
                        r_x   <= CORDIC_GAIN;
                        r_y   <= '0;
                        r_cnt <= '0;
                        r_st  <= CS_ITER;
                        if (z0 > QUARTER_Q) begin
                            r_z <= z0 - HALF_Q;  r_neg <= 1'b1;
                        end else if (z0 < -QUARTER_Q) begin
                            r_z <= z0 + HALF_Q;  r_neg <= 1'b1;
                        end else begin
                            r_z <= z0;           r_neg <= 1'b0;
                        end
                    end else if (i_start_vec) begin
                        r_rot <= 1'b0;
                        r_neg <= 1'b0;
                        r_cnt <= '0;
                        if (i_x == 0 && i_y == 0) begin
                            r_z    <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_st <= CS_NORM;
                            if (x64 < 0) begin
                                r_x <= -x64; r_y <= -y64; r_z <= HALF_Q;
                            end else begin
                                r_x <= x64;  r_y <= y64;  r_z <= '0;
                            end
                        end
                    end
                end
                CS_NORM: begin
                    // scale up so the vector keeps precision through the iterations
                    if (r_x < NORM_LIMIT && ay < NORM_LIMIT) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_st <= CS_ITER;
                    end
                end
                CS_ITER: begin
                    if (ccw) begin
                        r_x <= r_x - ysh; r_y <= r_y + xsh; r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + ysh; r_y <= r_y - xsh; r_z <= r_z + atn;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(CORDIC_STEPS - 1)) begin
                        r_st   <= CS_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_st <= CS_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_cos   = r_neg ? -r_x[31:0] : r_x[31:0];
    assign o_sin   = r_neg ? -r_y[31:0] : r_y[31:0];
    assign o_angle = zsum[31:32-ANGLE_BITS];

endmodule

// ----- hw/rtl/rpm_sqdiv.sv -----
// Bit-serial integer square root and signed divide, one bit per cycle.
module rpm_sqdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start_sqrt,
    input  logic               i_start_div,
    input  logic [63:0]        i_sq,
    input  logic signed [63:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic [31:0]        o_root,
    output logic signed [31:0] o_quo
);
    import rpm_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_ROOT = 3'b010,
        SQ_DIV  = 3'b100
    } t_sq;

    t_sq         r_st;
    logic [63:0] r_a, r_b;
    logic [31:0] r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_neg, r_done;

    logic [63:0] bitv;
    logic [64:0] trial;
    logic [32:0] rem_t;
    logic        ge;

    always_comb begin
        bitv  = 64'd1 << {r_cnt[4:0], 1'b0};
        trial = {1'b0, r_b} + {1'b0, bitv};
        rem_t = {r_rem, r_a[62]};
        ge    = rem_t >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= SQ_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                SQ_IDLE: begin
                    if (i_start_sqrt) begin
                        r_a   <= i_sq;
                        r_b   <= '0;
                        r_cnt <= 6'd31;
                        r_st  <= SQ_ROOT;
                    end else if (i_start_div) begin
                        r_a   <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                        r_neg <= i_num[63];
                        r_b   <= '0;
                        r_rem <= '0;
                        r_den <= i_den;
                        r_cnt <= 6'd62;
                        r_st  <= SQ_DIV;
                    end
                end
                SQ_ROOT: begin
                    if ({1'b0, r_a} >= trial) begin
                        r_a <= r_a - trial[63:0];
                        r_b <= (r_b >> 1) + bitv;
                    end else begin
                        r_b <= r_b >> 1;
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 6'd0) begin
                        r_st   <= SQ_IDLE;
                        r_done <= 1'b1;
                    end
                end
                SQ_DIV: begin
                    r_rem <= ge ? 32'(rem_t - {1'b0, r_den}) : rem_t[31:0];
                    r_b   <= {r_b[62:0], ge};
                    r_a   <= r_a << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 6'd0) begin
                        r_st   <= SQ_IDLE;
                        r_done <= 1'b1;
                    end
                end
                default: r_st <= SQ_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_b[31:0];
    assign o_quo  = r_neg ? -$signed(r_b[31:0]) : $signed(r_b[31:0]);

endmodule

// ----- hw/rtl/rpm_dp.sv -----
// Datapath: object state, config registers, shared multiplier and serial units.
module rpm_dp #(
    parameter int FRAC_BITS    = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rpm_pkg::t_cmd                    i_cmd,
    output logic                             o_unit_done,
    input  rpm_pkg::t_in_word                i_in,
    input  logic                             i_cfg_wr_en,
    input  logic [rpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rpm_pkg::t_out_word               o_out
);
    import rpm_pkg::*;

    localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > SAT_MAX) return 32'sh7FFFFFFF;
        if (v < SAT_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    // object state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_imp;
    logic [ANGLE_BITS-1:0] r_head;
    // config
    logic [30:0] r_inv_mass, r_max_speed;
    logic [16:0] r_elast;
    logic [20:0] r_friction;
    logic [15:0] r_zero_th;
    // latched input word
    logic [15:0]        r_ang_in;
    logic signed [31:0] r_magn, r_off, r_sx, r_sy;
    logic [19:0]        r_dt;
    // working values
    logic signed [31:0] r_c, r_s, r_t0, r_t1;
    logic [63:0]        r_acc;
    logic [31:0]        r_mag;
    logic               r_lim_en;
    logic [FRAC_BITS:0] r_fac;
    logic signed [65:0] r_prod;
    t_out_word          r_out;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [67:0] p_ext, sh30, shf, she, fv;
    logic signed [32:0] vx33, vy33, avx, avy;
    logic [31:0]        ang32, head32;

    logic                  cor_done, sqd_done;
    logic signed [31:0]    cor_cos, cor_sin, sqd_quo;
    logic [ANGLE_BITS-1:0] cor_ang;
    logic [31:0]           sqd_root;

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            U_M_C_IMP:   begin ma = 33'(r_c);  mb = 33'(r_imp); end
            U_M_S_IMP:   begin ma = 33'(r_s);  mb = 33'(r_imp); end
            U_M_T0_INVM: begin ma = 33'(r_t0); mb = $signed({2'b0, r_inv_mass}); end
            U_M_T1_INVM: begin ma = 33'(r_t1); mb = $signed({2'b0, r_inv_mass}); end
            U_M_T0_DT:   begin ma = 33'(r_t0); mb = $signed({13'b0, r_dt}); end
            U_M_T1_DT:   begin ma = 33'(r_t1); mb = $signed({13'b0, r_dt}); end
            U_M_VX_DT:   begin ma = 33'(r_vx); mb = $signed({13'b0, r_dt}); end
            U_M_VY_DT:   begin ma = 33'(r_vy); mb = $signed({13'b0, r_dt}); end
            U_M_VX_VX:   begin ma = 33'(r_vx); mb = 33'(r_vx); end
            U_M_VY_VY:   begin ma = 33'(r_vy); mb = 33'(r_vy); end
            U_M_VX_LIM:  begin ma = 33'(r_vx); mb = $signed({2'b0, r_max_speed}); end
            U_M_VY_LIM:  begin ma = 33'(r_vy); mb = $signed({2'b0, r_max_speed}); end
            U_M_FRIC_DT: begin
                ma = $signed({12'b0, r_friction});
                mb = $signed({13'b0, r_dt});
            end
            U_M_VX_FAC:  begin ma = 33'(r_vx); mb = $signed(33'(r_fac)); end
            U_M_VY_FAC:  begin ma = 33'(r_vy); mb = $signed(33'(r_fac)); end
            U_M_VX_NEL:  begin ma = 33'(r_vx); mb = 33'sd0 - $signed({16'b0, r_elast}); end
            U_M_VY_NEL:  begin ma = 33'(r_vy); mb = 33'sd0 - $signed({16'b0, r_elast}); end
            U_M_C_OFF:   begin ma = 33'(r_c);  mb = 33'(r_off); end
            U_M_S_OFF:   begin ma = 33'(r_s);  mb = 33'(r_off); end
            default: ;
        endcase
        prod   = ma * mb;
        p_ext  = {{2{r_prod[65]}}, r_prod};
        sh30   = p_ext >>> 30;
        shf    = p_ext >>> FRAC_BITS;
        she    = p_ext >>> ELAST_BITS;
        fv     = (68'sd1 <<< FRAC_BITS) - shf;
        vx33   = {r_vx[31], r_vx};
        vy33   = {r_vy[31], r_vy};
        avx    = vx33[32] ? -vx33 : vx33;
        avy    = vy33[32] ? -vy33 : vy33;
        ang32  = 32'(r_ang_in);
        head32 = 32'(r_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px        <= '0;
            r_py        <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_imp       <= '0;
            r_head      <= '0;
            r_inv_mass  <= 31'd65536;
            r_elast     <= 17'd52429;
            r_friction  <= 21'd6554;
            r_max_speed <= 31'd655360;
            r_zero_th   <= 16'd66;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_INV_MASS:  r_inv_mass  <= i_cfg_data[30:0];
                    CFG_ELAST:     r_elast     <= i_cfg_data[16:0];
                    CFG_FRICTION:  r_friction  <= i_cfg_data[20:0];
                    CFG_MAX_SPEED: r_max_speed <= i_cfg_data[30:0];
                    CFG_ZERO_TH:   r_zero_th   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (i_cmd.go) begin
                case (i_cmd.op)
                    U_PLACE: begin
                        r_px   <= r_sx;
                        r_py   <= r_sy;
                        r_vx   <= '0;
                        r_vy   <= '0;
                        r_imp  <= '0;
                        r_head <= '0;
                    end
                    U_LOAD_PUSH: begin
                        r_head <= ang32[ANGLE_BITS-1:0];
                        r_imp  <= r_magn;
                    end
                    U_STOP: begin
                        r_vx  <= '0;
                        r_vy  <= '0;
                        r_imp <= '0;
                    end
                    U_M_C_IMP, U_M_S_IMP, U_M_T0_INVM, U_M_T1_INVM, U_M_T0_DT, U_M_T1_DT,
                    U_M_VX_DT, U_M_VY_DT, U_M_VX_VX, U_M_VY_VY, U_M_VX_LIM, U_M_VY_LIM,
                    U_M_FRIC_DT, U_M_VX_FAC, U_M_VY_FAC, U_M_VX_NEL, U_M_VY_NEL,
                    U_M_C_OFF, U_M_S_OFF:
                        r_prod <= prod;
                    U_W_T0_30:  r_t0 <= sat32(sh30);
                    U_W_T1_30:  r_t1 <= sat32(sh30);
                    U_W_T0_F:   r_t0 <= sat32(shf);
                    U_W_T1_F:   r_t1 <= sat32(shf);
                    U_W_VX_ADD: r_vx <= sat32(68'(r_vx) + shf);
                    U_W_VY_ADD: r_vy <= sat32(68'(r_vy) + shf);
                    U_W_PX_ADD: r_px <= sat32(68'(r_px) + shf);
                    U_W_PY_ADD: r_py <= sat32(68'(r_py) + shf);
                    U_W_SQ0:    r_acc <= r_prod[63:0];
                    U_W_SQ1:    r_acc <= r_acc + r_prod[63:0];
                    U_W_FACT:   r_fac <= fv[67] ? '0 : fv[FRAC_BITS:0];
                    U_W_VX_F:   r_vx <= sat32(shf);
                    U_W_VY_F:   r_vy <= sat32(shf);
                    U_W_VX_E:   r_vx <= sat32(she);
                    U_W_VY_E:   r_vy <= sat32(she);
                    U_W_PX_30:  r_px <= sat32(68'(r_px) + sh30);
                    U_W_PY_30:  r_py <= sat32(68'(r_py) + sh30);
                    U_LIMCHK:   r_lim_en <= r_mag > {1'b0, r_max_speed};
                    U_HNEG:     r_head <= '0 - r_head;
                    U_HREFL:    r_head <= HALF_TURN - r_head;
                    U_SNAP: begin
                        if (avx < $signed({17'b0, r_zero_th})) r_vx <= '0;
                        if (avy < $signed({17'b0, r_zero_th})) r_vy <= '0;
                        if (r_imp < $signed({16'b0, r_zero_th})) r_imp <= '0;
                    end
                    default: ;
                endcase
            end

            if (o_unit_done) begin
                case (i_cmd.op)
                    U_SINCOS: begin
                        r_c <= cor_cos;
                        r_s <= cor_sin;
                    end
                    U_ATAN:  r_head <= cor_ang;
                    U_SQRT:  r_mag  <= sqd_root;
                    U_DIV_X: if (r_lim_en) r_vx <= sqd_quo;
                    U_DIV_Y: if (r_lim_en) r_vy <= sqd_quo;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ang_in <= i_in.angle_in;
            r_magn   <= i_in.magnitude;
            r_dt     <= i_in.delta_time;
            r_off    <= i_in.offset;
            r_sx     <= i_in.start_x;
            r_sy     <= i_in.start_y;
        end
        if (i_cmd.load_out) begin
            r_out.pos_x   <= r_px;
            r_out.pos_y   <= r_py;
            r_out.vel_x   <= r_vx;
            r_out.vel_y   <= r_vy;
            r_out.heading <= head32[15:0];
        end
    end

    rpm_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_rot (i_cmd.go && i_cmd.op == U_SINCOS),
        .i_start_vec (i_cmd.go && i_cmd.op == U_ATAN),
        .i_angle     (r_head),
        .i_x         (r_vx),
        .i_y         (r_vy),
        .o_done      (cor_done),
        .o_cos       (cor_cos),
        .o_sin       (cor_sin),
        .o_angle     (cor_ang)
    );

    rpm_sqdiv u_sqdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_sqrt (i_cmd.go && i_cmd.op == U_SQRT),
        .i_start_div  (i_cmd.go && (i_cmd.op == U_DIV_X || i_cmd.op == U_DIV_Y)),
        .i_sq         (r_acc),
        .i_num        (r_prod[63:0]),
        .i_den        (r_mag),
        .o_done       (sqd_done),
        .o_root       (sqd_root),
        .o_quo        (sqd_quo)
    );

    assign o_unit_done = cor_done | sqd_done;
    assign o_out       = r_out;

endmodule

// ----- hw/rtl/rpm_ctrl.sv -----
// Controller: microcode sequencer and handshake for both channels.
module rpm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_func,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rpm_pkg::t_cmd        o_cmd,
    input  logic                 i_unit_done
);
    import rpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;
    t_uinst          uinst;
    logic            accept, load_out;

    always_comb begin
        uinst    = uc_rom(r_pc);
        accept   = (r_state == S_IDLE) && i_in_valid;
        load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pc    = uc_start(i_func);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (is_long(uinst.op)) begin
                    n_state = S_WAIT;
                end else if (uinst.last) begin
                    n_state = S_DONE;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_unit_done) begin
                    if (uinst.last) begin
                        n_state = S_DONE;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_EXEC;
                    end
                end
            end
            S_DONE: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        o_cmd.op       = uinst.op;
        o_cmd.go       = (r_state == S_EXEC);
        o_cmd.load_in  = accept;
        o_cmd.load_out = load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- verif/rigid_point_motion_step_unit_test.sv -----
// Self-checking testbench for the point motion step unit: directed and random words.
module rigid_point_motion_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rpm_pkg::*;

    localparam int  STALL_LIMIT = 20000;
    localparam int  DRAIN_CYCLES = 400;
    localparam int  HOLD_CYCLES = 500;

    localparam longint ARC_TAB [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_word i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out_word o_out;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rigid_point_motion_step_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // object state and registers as the predictor sees them
    longint pos_x_m, pos_y_m, vel_x_m, vel_y_m, impulse_m;
    logic [15:0] heading_m;
    longint inv_mass_m, elast_m, fric_m, speed_lim_m, snap_th_m;

    t_out_word state_q[$];
    int errors = 0;
    bit idle_en = 1'b0;
    int hold_token = 0;
    int quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic rotate_unit(input logic [15:0] h, output longint c, output longint s);
        logic [31:0] a;
        longint z, x, y, t;
        bit neg;
        a = {h, 16'h0};
        z = longint'($signed(a));
        x = 64'sd652032874;
        y = 0;
        neg = 1'b0;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648; neg = 1'b1;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648; neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z -= ARC_TAB[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z += ARC_TAB[i];
            end
            x = t;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic logic [15:0] heading_of(input longint yv, input longint xv);
        longint x, y, z, t, m;
        logic [63:0] r;
        x = xv; y = yv; z = 0;
        if (x == 0 && y == 0) return 16'h0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'sd2147483648;
        end
        m = (x > abs64(y)) ? x : abs64(y);
        while (m < 64'sd70368744177664) begin
            x *= 2; y *= 2; m *= 2;
        end
        for (int i = 0; i < 16; i++) begin
            if (y < 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z -= ARC_TAB[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z += ARC_TAB[i];
            end
            x = t;
        end
        r = ({32'h0, z[31:0]} + 64'd32768) >> 16;
        return r[15:0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic euler_advance(input longint dt);
        longint c, s, fx, fy, ax, ay;
        rotate_unit(heading_m, c, s);
        fx = sat32((c * impulse_m) >>> 30);
        fy = sat32((s * impulse_m) >>> 30);
        ax = sat32((fx * inv_mass_m) >>> 16);
        ay = sat32((fy * inv_mass_m) >>> 16);
        vel_x_m = sat32(vel_x_m + ((ax * dt) >>> 16));
        vel_y_m = sat32(vel_y_m + ((ay * dt) >>> 16));
        pos_x_m = sat32(pos_x_m + ((vel_x_m * dt) >>> 16));
        pos_y_m = sat32(pos_y_m + ((vel_y_m * dt) >>> 16));
    endtask

    task automatic snap_small();
        if (abs64(vel_x_m) < snap_th_m) vel_x_m = 0;
        if (abs64(vel_y_m) < snap_th_m) vel_y_m = 0;
        if (impulse_m < snap_th_m) impulse_m = 0;
    endtask

    task automatic next_state(input t_in_word w);
        longint dt, c, s, mag, fac;
        logic [63:0] sq;
        dt = longint'(w.delta_time);
        case (w.func)
            FN_PLACE: begin
                pos_x_m = w.start_x; pos_y_m = w.start_y;
                vel_x_m = 0; vel_y_m = 0; impulse_m = 0; heading_m = 0;
            end
            FN_PUSH: begin
                heading_m = w.angle_in;
                impulse_m = w.magnitude;
                euler_advance(dt);
                snap_small();
            end
            FN_COAST: begin
                euler_advance(dt);
                sq = 64'(vel_x_m * vel_x_m) + 64'(vel_y_m * vel_y_m);
                mag = longint'(root_floor(sq));
                if (mag > speed_lim_m) begin
                    vel_x_m = (vel_x_m * speed_lim_m) / mag;
                    vel_y_m = (vel_y_m * speed_lim_m) / mag;
                end
                heading_m = heading_of(vel_y_m, vel_x_m);
                fac = 64'sd65536 - ((fric_m * dt) >>> 16);
                if (fac < 0) fac = 0;
                vel_x_m = sat32((vel_x_m * fac) >>> 16);
                vel_y_m = sat32((vel_y_m * fac) >>> 16);
                snap_small();
            end
            FN_BNC_H: begin
                vel_y_m = sat32((vel_y_m * -elast_m) >>> ELAST_BITS);
                heading_m = 16'h0 - heading_m;
                rotate_unit(heading_m, c, s);
                pos_y_m = sat32(pos_y_m + ((s * longint'(w.offset)) >>> 30));
            end
            FN_BNC_V: begin
                vel_x_m = sat32((vel_x_m * -elast_m) >>> ELAST_BITS);
                heading_m = 16'h8000 - heading_m;
                rotate_unit(heading_m, c, s);
                pos_x_m = sat32(pos_x_m + ((c * longint'(w.offset)) >>> 30));
            end
            FN_STOP: begin
                vel_x_m = 0; vel_y_m = 0; impulse_m = 0;
            end
            default: ;
        endcase
        state_q.push_back('{pos_x: pos_x_m[31:0], pos_y: pos_y_m[31:0],
                            vel_x: vel_x_m[31:0], vel_y: vel_y_m[31:0],
                            heading: heading_m});
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (state_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out);
                errors++;
            end else begin
                exp_w = state_q.pop_front();
                if (o_out.pos_x !== exp_w.pos_x) begin
                    $display("%0t: pos_x exp %h got %h", $time, exp_w.pos_x, o_out.pos_x);
                    errors++;
                end
                if (o_out.pos_y !== exp_w.pos_y) begin
                    $display("%0t: pos_y exp %h got %h", $time, exp_w.pos_y, o_out.pos_y);
                    errors++;
                end
                if (o_out.vel_x !== exp_w.vel_x) begin
                    $display("%0t: vel_x exp %h got %h", $time, exp_w.vel_x, o_out.vel_x);
                    errors++;
                end
                if (o_out.vel_y !== exp_w.vel_y) begin
                    $display("%0t: vel_y exp %h got %h", $time, exp_w.vel_y, o_out.vel_y);
                    errors++;
                end
                if (o_out.heading !== exp_w.heading) begin
                    $display("%0t: heading exp %h got %h", $time, exp_w.heading,
                             o_out.heading);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        int token_seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            token_seen = hold_token;
        end else if (hold_token != token_seen) begin
            token_seen = hold_token;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_en && ($urandom_range(0, 99) < 10);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("rigid_point_motion_step_unit test failed");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        if (idle_en) begin
            while ($urandom_range(0, 99) < 10) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (o_in_stall);
        next_state(w);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (state_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_INV_MASS:  inv_mass_m  = val & 64'h7FFF_FFFF;
            CFG_ELAST:     elast_m     = val & 64'h1_FFFF;
            CFG_FRICTION:  fric_m      = val & 64'h1F_FFFF;
            CFG_MAX_SPEED: speed_lim_m = val & 64'h7FFF_FFFF;
            CFG_ZERO_TH:   snap_th_m   = val & 64'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(input longint im, input longint el, input longint fr,
                            input longint ms, input longint zt);
        settle();
        write_reg(CFG_INV_MASS, im);
        write_reg(CFG_ELAST, el);
        write_reg(CFG_FRICTION, fr);
        write_reg(CFG_MAX_SPEED, ms);
        write_reg(CFG_ZERO_TH, zt);
    endtask

    function automatic t_in_word make_word(input logic [2:0] fn);
        t_in_word w;
        w.func = fn;
        w.angle_in = 16'($urandom);
        w.magnitude = ($urandom_range(0, 3) == 0) ? $urandom
                    : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        w.delta_time = ($urandom_range(0, 4) == 0) ? 20'($urandom)
                     : 20'($urandom_range(0, 16384));
        w.offset = ($urandom_range(0, 2) == 0) ? $urandom
                 : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        w.start_x = ($urandom_range(0, 2) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        w.start_y = ($urandom_range(0, 2) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        return w;
    endfunction

    function automatic t_in_word random_word();
        int p;
        logic [2:0] fn;
        p = $urandom_range(0, 99);
        if (p < 8)       fn = FN_PLACE;
        else if (p < 35) fn = FN_PUSH;
        else if (p < 65) fn = FN_COAST;
        else if (p < 76) fn = FN_BNC_H;
        else if (p < 87) fn = FN_BNC_V;
        else if (p < 94) fn = FN_STOP;
        else             fn = 3'(6 + $urandom_range(0, 1));
        return make_word(fn);
    endfunction

    task automatic test_directed();
        t_in_word w;
        w = make_word(FN_PLACE);
        w.start_x = 32'sh7FFF_FFFF; w.start_y = 32'sh8000_0000;
        send_word(w);
        w = make_word(FN_PUSH);
        w.angle_in = 16'hFFFF; w.magnitude = 32'sh7FFF_FFFF; w.delta_time = 20'hFFFFF;
        send_word(w);       // saturates
        w = make_word(FN_COAST); w.delta_time = 20'hFFFFF;
        send_word(w);       // speed limit and friction beyond one step
        w = make_word(FN_PLACE); w.start_x = 0; w.start_y = 0;
        send_word(w);
        w = make_word(FN_COAST); send_word(w);      // zero velocity heading
        w = make_word(FN_PUSH);
        w.angle_in = 16'h4000; w.magnitude = -32'sd200000; w.delta_time = 20'h10000;
        send_word(w);       // negative strength snaps to zero
        w = make_word(FN_PUSH);
        w.angle_in = 16'h0000; w.magnitude = 32'sh8000_0000; w.delta_time = 20'h8000;
        send_word(w);
        w = make_word(FN_BNC_H); w.offset = 32'sh7FFF_FFFF; send_word(w);
        w = make_word(FN_BNC_V); w.offset = 32'sh8000_0000; send_word(w);
        w = make_word(3'd6); send_word(w);
        w = make_word(3'd7); send_word(w);
        w = make_word(FN_PUSH); w.angle_in = 16'h2000; w.magnitude = 32'sd3 << 16;
        send_word(w);
        w = make_word(FN_COAST); w.delta_time = 0; send_word(w);
        w = make_word(FN_STOP); send_word(w);
        w = make_word(FN_BNC_V); send_word(w);
    endtask

    task automatic random_run(input int count);
        t_in_word w;
        for (int n = 0; n < count; n++) begin
            w = random_word();
            send_word(w);
        end
    endtask

    task automatic test_register_extremes();
        set_regs(0, 0, 0, 0, 0);
        random_run(120);
        set_regs(64'h7FFF_FFFF, 65536, 1048576, 64'h7FFF_FFFF, 65535);
        random_run(120);
        set_regs(1 << 12, 32768, 1 << 10, 1 << 22, 0);
        random_run(120);
        set_regs($urandom_range(0, 1 << 20), $urandom_range(0, 65536),
                 $urandom_range(0, 1048576), $urandom_range(0, 1 << 25),
                 $urandom_range(0, 512));
        random_run(120);
    endtask

    task automatic test_random_traffic();
        set_regs(65536, 52429, 6554, 655360, 66);
        idle_en = 1'b0;     // back-to-back stretch
        random_run(300);
        idle_en = 1'b1;
        random_run(800);
    endtask

    task automatic test_output_hold();
        hold_token++;
        random_run(60);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pos_x_m = 0; pos_y_m = 0; vel_x_m = 0; vel_y_m = 0; impulse_m = 0;
        heading_m = 0;
        inv_mass_m = 65536; elast_m = 52429; fric_m = 6554;
        speed_lim_m = 655360; snap_th_m = 66;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_en = 1'b1;
        test_directed();
        test_register_extremes();
        test_random_traffic();
        test_output_hold();
        settle();
        if (errors == 0)
            $display("rigid_point_motion_step_unit test passed");
        else
            $display("rigid_point_motion_step_unit test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rpm_pkg.sv
hw/rtl/rpm_cordic.sv
hw/rtl/rpm_sqdiv.sv
hw/rtl/rpm_dp.sv
hw/rtl/rpm_ctrl.sv
hw/rtl/rigid_point_motion_step_unit.sv
verif/rigid_point_motion_step_unit_test.sv
